// File: sv/grid_raycast_column_defines.svh
// Assertion macros for the port checker of the ray caster.
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH

// A property that is checked on every rising clock edge outside reset.
`define GRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define GRC_NEVER(label, cond, msg) \
  `GRC_ASSERT(label, !(cond), msg)

`endif

// File: sv/grc_pkg.sv
package grc_pkg;

  // Screen and walk geometry.
  localparam int COLUMNS   = 53;
  localparam int ROWS_N    = 21;
  localparam int MAX_STEPS = 64;

  // Field and datapath widths.
  localparam int COL_W    = 6;
  localparam int POS_W    = 24;
  localparam int DIR_W    = 16;
  localparam int PITCH_W  = 3;
  localparam int DIST_W   = 16;
  localparam int ROW_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CAM_W    = 17;
  localparam int CAM_ENTRIES = 2 ** COL_W;
  localparam int PROD_W   = DIR_W + CAM_W;
  localparam int RAY_W    = 18;
  localparam int FRAC_W   = 8;
  localparam int COORD_W  = 18;
  localparam int DLT_W    = 32;
  localparam int SD_W     = 48;
  localparam int STEP_W   = $clog2(MAX_STEPS + 1);
  localparam int HGT_W    = 13;
  localparam int SPAN_W   = 15;
  localparam int SH_W     = 20;

  // Divider chain: one quotient bit per cell.
  localparam int DIV_CELLS = 32;
  localparam int DVD_W     = DIV_CELLS;
  localparam int DVS_W     = 17;
  localparam int REM_W     = DVS_W;

  localparam logic [DVD_W-1:0] DELTA_DIVIDEND  = DVD_W'(64'd1 << 30);
  localparam logic [DVD_W-1:0] HEIGHT_DIVIDEND = DVD_W'(ROWS_N * 256);
  localparam logic [DLT_W-1:0] DELTA_INF       = DLT_W'(64'd1 << 31);

  // Room hash. Only bits 0 to 2 of the final hash are used, and the last
  // multiplier is odd with its low three bits equal to one, so the last
  // multiplication leaves those bits unchanged.
  localparam int HASH_SH = 16;
  localparam int HASH_W  = HASH_SH + 3;
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam int MIRROR_OFS = 10000;

  // Shade thresholds.
  localparam int SHADE_STEP = 2560;
  localparam int SHADE_MUL  = 12;
  localparam int SHADE_MAX  = 9;

  typedef enum logic [1:0] {
    TAG_X,
    TAG_Y,
    TAG_H
  } grc_tag_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POS_X,
    REG_CAM_POS_Y,
    REG_VIEW_DIR_X,
    REG_VIEW_DIR_Y,
    REG_CAM_PLANE_X,
    REG_CAM_PLANE_Y,
    REG_ROW_PITCH
  } grc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVX,
    ST_DIVY,
    ST_DWAIT,
    ST_INIT,
    ST_WALK,
    ST_DIST,
    ST_HDIV,
    ST_HWAIT,
    ST_DONE
  } grc_state_e;

  // One word moving down the divider chain.
  typedef struct packed {
    logic             valid;
    grc_tag_e         tag;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dq;
    logic [DVS_W-1:0] dvs;
  } grc_div_t;

  typedef logic signed [CAM_W-1:0] grc_cam_tab_t [CAM_ENTRIES];

  // Camera-space coordinate of each column, in Q2.14.
  function automatic grc_cam_tab_t build_cam_tab();
    grc_cam_tab_t tab;
    int v;
    for (int i = 0; i < CAM_ENTRIES; i++) begin
      v = (2 * i * 16384) / COLUMNS - 16384;
      tab[i] = CAM_W'(v);
    end
    return tab;
  endfunction

  localparam grc_cam_tab_t CAM_TAB = build_cam_tab();

  // ASCII shade ramp, darkest first.
  function automatic logic [CHAR_W-1:0] shade_char(logic [3:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      4'd0:    c = "@";
      4'd1:    c = "%";
      4'd2:    c = "#";
      4'd3:    c = "*";
      4'd4:    c = "+";
      4'd5:    c = "=";
      4'd6:    c = "-";
      4'd7:    c = ":";
      4'd8:    c = ".";
      default: c = " ";
    endcase
    return c;
  endfunction

endpackage

// File: sv/grc_div_cell.sv
module grc_div_cell
  import grc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  grc_div_t cell_i,
  output grc_div_t cell_o
);

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;
  grc_div_t       nxt;
  grc_div_t       pay_q;
  logic           valid_q;

  // One restoring division step: shift in the next dividend bit and subtract.
  always_comb begin
    trial = {cell_i.rem, cell_i.dq[DVD_W-1]};
    diff  = trial - {1'b0, cell_i.dvs};
    ge    = (trial >= {1'b0, cell_i.dvs});
    nxt   = cell_i;
    nxt.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    nxt.dq  = {cell_i.dq[DVD_W-2:0], ge};
  end

  // The valid bit is control state; the rest of the word needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= nxt;
  end

  assign cell_o = '{valid: valid_q, tag: pay_q.tag, rem: pay_q.rem,
                    dq: pay_q.dq, dvs: pay_q.dvs};

endmodule

// File: sv/grc_div_chain.sv
module grc_div_chain
  import grc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  grc_div_t div_i,
  output grc_div_t div_o
);

  grc_div_t link [DIV_CELLS+1];

  assign link[0] = div_i;

  // Each cell resolves one quotient bit and hands the word to the next.
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    grc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign div_o = link[DIV_CELLS];

endmodule

// File: sv/grid_raycast_column.sv
// Casts one ray per screen column through a procedural grid of 4x4 rooms.
// Input channel: in_valid_i / in_stall_o with the column index; a word is
// taken when valid is high and stall is low. Stall stays high while a column
// is in work, so one column is handled at a time.
// Output channel: out_valid_o / out_stall_i with distance, side, span rows,
// shade character and hit flag, held in an output register. A new column can
// be taken while that register still waits on a stalled receiver.
// From the accepting edge to the result word, a column makes two passes
// through the 32-cell divider chain (ray reciprocals, then wall height) and
// the grid walk at one cell per cycle, 1 to 64 steps.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while no column is in work.
// Reset loads the default camera and clears both channels; no clearing pass
// is needed.
module grid_raycast_column
  import grc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [COL_W-1:0]     column_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DIST_W-1:0]    wall_distance_o,
  output logic                 hit_side_o,
  output logic [ROW_W-1:0]     span_start_o,
  output logic [ROW_W-1:0]     span_end_o,
  output logic [CHAR_W-1:0]    wall_char_o,
  output logic                 hit_found_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i
);

  grc_state_e state_q, state_d;

  logic signed [POS_W-1:0]   cam_pos_x_q, cam_pos_y_q;
  logic signed [DIR_W-1:0]   view_dir_x_q, view_dir_y_q;
  logic signed [DIR_W-1:0]   cam_plane_x_q, cam_plane_y_q;
  logic signed [PITCH_W-1:0] row_pitch_q;

  logic [COL_W-1:0]          col_q;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q;
  logic                      rx_neg_q, ry_neg_q, ax_zero_q, ay_zero_q;
  logic [DVS_W-1:0]          ay_q;
  logic [DLT_W-1:0]          dlt_x_q, dlt_y_q;
  logic [SD_W-1:0]           sx_q, sy_q;
  logic signed [COORD_W-1:0] mx_q, my_q;
  logic [STEP_W-1:0]         n_q;
  logic                      side_q, hit_q;
  logic [DIST_W-1:0]         dist_q;
  logic [HGT_W-1:0]          hgt_q;
  logic                      out_valid_q;

  logic signed [CAM_W-1:0]   cam_v;
  logic signed [RAY_W-1:0]   rx, ry;
  logic [DVS_W-1:0]          ax, ay;
  grc_div_t                  div_in, div_out;
  logic                      solid_now, walk_hit, walk_end, out_free;
  logic [SD_W-1:0]           dstep_x, dstep_y, perp;
  logic [FRAC_W:0]           frx, fry;

  // Grid cell test: mirror negative coordinates, split into room and local
  // position, then check pillars, walls and doors.
  function automatic logic is_solid(logic signed [COORD_W-1:0] c_x,
                                    logic signed [COORD_W-1:0] c_y);
    logic [COORD_W-1:0] ux, uy;
    logic [HASH_W-1:0]  hx, hy, s;
    logic [2:0]         sb;
    logic [1:0]         lx, ly;
    logic               res;
    ux = (c_x < 0) ? COORD_W'(-c_x) + COORD_W'(MIRROR_OFS) : COORD_W'(c_x);
    uy = (c_y < 0) ? COORD_W'(-c_y) + COORD_W'(MIRROR_OFS) : COORD_W'(c_y);
    lx = ux[1:0];
    ly = uy[1:0];
    hx = HASH_W'(HASH_W'(ux[COORD_W-1:2]) * HASH_MUL_X[HASH_W-1:0]);
    hy = HASH_W'(HASH_W'(uy[COORD_W-1:2]) * HASH_MUL_Y[HASH_W-1:0]);
    s  = hx ^ hy;
    sb = s[2:0] ^ s[HASH_SH+2:HASH_SH];
    if (lx == 2'd0 && ly == 2'd0) begin
      res = 1'b1;
    end else if (lx == 2'd0) begin
      res = !(ly == 2'd2 && sb[0]);
    end else if (ly == 2'd0) begin
      res = !(lx == 2'd2 && sb[1]);
    end else begin
      res = (lx == 2'd2) && (ly == 2'd2) && sb[2];
    end
    return res;
  endfunction

  grc_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  // Ray direction from the registered plane products.
  always_comb begin
    cam_v = CAM_TAB[col_q];
    rx = RAY_W'(view_dir_x_q) + RAY_W'(prod_x_q >>> 14);
    ry = RAY_W'(view_dir_y_q) + RAY_W'(prod_y_q >>> 14);
    ax = rx[RAY_W-1] ? DVS_W'(-rx) : DVS_W'(rx);
    ay = ry[RAY_W-1] ? DVS_W'(-ry) : DVS_W'(ry);
  end

  // Walk datapath terms.
  always_comb begin
    dstep_x   = SD_W'({dlt_x_q, 8'h00});
    dstep_y   = SD_W'({dlt_y_q, 8'h00});
    frx       = rx_neg_q ? {1'b0, cam_pos_x_q[FRAC_W-1:0]}
                         : (FRAC_W+1)'(256) - {1'b0, cam_pos_x_q[FRAC_W-1:0]};
    fry       = ry_neg_q ? {1'b0, cam_pos_y_q[FRAC_W-1:0]}
                         : (FRAC_W+1)'(256) - {1'b0, cam_pos_y_q[FRAC_W-1:0]};
    solid_now = is_solid(mx_q, my_q);
    walk_hit  = (n_q != '0) && solid_now;
    walk_end  = walk_hit || (n_q == STEP_W'(MAX_STEPS));
    perp      = side_q ? sy_q - dstep_y : sx_q - dstep_x;
    out_free  = !out_valid_q || !out_stall_i;
  end

  // Sequencer: next state, input stall and divider feed.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    div_in     = '{valid: 1'b0, tag: TAG_X, rem: '0, dq: '0, dvs: '0};
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIVX;
      ST_DIVX: begin
        div_in  = '{valid: 1'b1, tag: TAG_X, rem: '0, dq: DELTA_DIVIDEND, dvs: ax};
        state_d = ST_DIVY;
      end
      ST_DIVY: begin
        div_in  = '{valid: 1'b1, tag: TAG_Y, rem: '0, dq: DELTA_DIVIDEND, dvs: ay_q};
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_out.valid && div_out.tag == TAG_Y) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST: state_d = ST_HDIV;
      ST_HDIV: begin
        div_in  = '{valid: 1'b1, tag: TAG_H, rem: '0, dq: HEIGHT_DIVIDEND,
                    dvs: (dist_q == '0) ? DVS_W'(1) : DVS_W'(dist_q)};
        state_d = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (div_out.valid && div_out.tag == TAG_H) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_x_q   <= POS_W'(640);
      cam_pos_y_q   <= POS_W'(640);
      view_dir_x_q  <= -DIR_W'(16384);
      view_dir_y_q  <= '0;
      cam_plane_x_q <= '0;
      cam_plane_y_q <= DIR_W'(10813);
      row_pitch_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (grc_reg_e'(cfg_index_i))
        REG_CAM_POS_X:   cam_pos_x_q   <= cfg_data_i;
        REG_CAM_POS_Y:   cam_pos_y_q   <= cfg_data_i;
        REG_VIEW_DIR_X:  view_dir_x_q  <= cfg_data_i[DIR_W-1:0];
        REG_VIEW_DIR_Y:  view_dir_y_q  <= cfg_data_i[DIR_W-1:0];
        REG_CAM_PLANE_X: cam_plane_x_q <= cfg_data_i[DIR_W-1:0];
        REG_CAM_PLANE_Y: cam_plane_y_q <= cfg_data_i[DIR_W-1:0];
        REG_ROW_PITCH:   row_pitch_q   <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Ray setup, grid walk and distance registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          col_q <= column_i;
        end
      end
      ST_MUL: begin
        prod_x_q <= PROD_W'(cam_plane_x_q * cam_v);
        prod_y_q <= PROD_W'(cam_plane_y_q * cam_v);
      end
      ST_DIVX: begin
        rx_neg_q  <= rx[RAY_W-1];
        ry_neg_q  <= ry[RAY_W-1];
        ax_zero_q <= (ax == '0);
        ay_zero_q <= (ay == '0);
        ay_q      <= ay;
      end
      ST_DWAIT: begin
        if (div_out.valid && div_out.tag == TAG_X) begin
          dlt_x_q <= ax_zero_q ? DELTA_INF : div_out.dq;
        end
        if (div_out.valid && div_out.tag == TAG_Y) begin
          dlt_y_q <= ay_zero_q ? DELTA_INF : div_out.dq;
        end
      end
      ST_INIT: begin
        sx_q   <= SD_W'(SD_W'(frx) * SD_W'(dlt_x_q));
        sy_q   <= SD_W'(SD_W'(fry) * SD_W'(dlt_y_q));
        mx_q   <= COORD_W'(cam_pos_x_q >>> FRAC_W);
        my_q   <= COORD_W'(cam_pos_y_q >>> FRAC_W);
        n_q    <= '0;
        side_q <= 1'b0;
        hit_q  <= 1'b0;
      end
      ST_WALK: begin
        if (walk_hit) begin
          hit_q <= 1'b1;
        end else if (!walk_end) begin
          n_q <= n_q + STEP_W'(1);
          if (sx_q < sy_q) begin
            sx_q   <= sx_q + dstep_x;
            mx_q   <= rx_neg_q ? mx_q - COORD_W'(1) : mx_q + COORD_W'(1);
            side_q <= 1'b0;
          end else begin
            sy_q   <= sy_q + dstep_y;
            my_q   <= ry_neg_q ? my_q - COORD_W'(1) : my_q + COORD_W'(1);
            side_q <= 1'b1;
          end
        end
      end
      ST_DIST: begin
        if (!hit_q || (perp[SD_W-1:DIST_W+16] != '0)) begin
          dist_q <= '1;
        end else begin
          dist_q <= perp[DIST_W+15:16];
        end
      end
      ST_HWAIT: begin
        if (div_out.valid && div_out.tag == TAG_H) begin
          hgt_q <= div_out.dq[HGT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Span rows and shade from the final distance.
  logic signed [SPAN_W-1:0] mid, half_h, st, en;
  logic [SH_W-1:0]          dist12;
  logic [3:0]               shade;

  always_comb begin
    mid    = SPAN_W'(ROWS_N / 2) + SPAN_W'(row_pitch_q);
    half_h = SPAN_W'(hgt_q[HGT_W-1:1]);
    st     = mid - half_h;
    en     = mid + half_h;
    if (st < 0) begin
      st = '0;
    end else if (st > SPAN_W'(ROWS_N - 1)) begin
      st = SPAN_W'(ROWS_N - 1);
    end
    if (en < 0) begin
      en = '0;
    end else if (en > SPAN_W'(ROWS_N - 1)) begin
      en = SPAN_W'(ROWS_N - 1);
    end
    dist12 = SH_W'(dist_q) * SH_W'(SHADE_MUL);
    shade  = '0;
    for (int k = 1; k <= SHADE_MAX; k++) begin
      if (dist12 >= SH_W'(SHADE_STEP * k)) begin
        shade = shade + 4'd1;
      end
    end
    if (side_q && shade < 4'(SHADE_MAX)) begin
      shade = shade + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      wall_distance_o <= dist_q;
      hit_side_o      <= side_q;
      span_start_o    <= st[ROW_W-1:0];
      span_end_o      <= en[ROW_W-1:0];
      wall_char_o     <= shade_char(shade);
      hit_found_o     <= hit_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/grc_port_checker.sv
`include "grid_raycast_column_defines.svh"

module grc_port_checker
  import grc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [DIST_W-1:0]    wall_distance_o,
  input logic [ROW_W-1:0]     span_start_o,
  input logic [ROW_W-1:0]     span_end_o,
  input logic [CHAR_W-1:0]    wall_char_o,
  input logic                 hit_found_o
);

  // A stalled result word stays in place.
  `GRC_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(wall_distance_o) && $stable(wall_char_o),
    "result word changed under stall")

  // A column in work blocks the next one.
  `GRC_ASSERT(a_one_column, in_valid_i && !in_stall_o |=> in_stall_o,
    "input taken while a column is in work")

  // A ray that runs out of steps reports the saturated distance.
  `GRC_NEVER(a_miss_dist,
    out_valid_o && !hit_found_o && wall_distance_o != 16'hFFFF,
    "miss without saturated distance")

  // The span is ordered and stays on the screen.
  `GRC_NEVER(a_span_order,
    out_valid_o && (span_start_o > span_end_o || span_end_o > ROW_W'(ROWS_N - 1)),
    "wall span out of order or off screen")

endmodule

bind grid_raycast_column grc_port_checker u_port_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import grc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PHASES = 9;
  localparam int COLUMNS_PER_PHASE = 215;

  // One ray result as the output port presents it.
  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              side;
    logic [ROW_W-1:0]  first_row;
    logic [ROW_W-1:0]  last_row;
    logic [CHAR_W-1:0] shade;
    logic              hit;
  } ray_hit_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [COL_W-1:0]     column_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DIST_W-1:0]    wall_distance_o;
  logic                 hit_side_o;
  logic [ROW_W-1:0]     span_start_o;
  logic [ROW_W-1:0]     span_end_o;
  logic [CHAR_W-1:0]    wall_char_o;
  logic                 hit_found_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [POS_W-1:0]     cfg_data_i;

  grid_raycast_column dut (.*);

  // Camera registers as the predictor sees them, sign-extended.
  longint cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, pitch;

  logic [COL_W-1:0] column_queue[$];
  ray_hit_t         ray_queue[$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               mismatches;
  int               cycles;
  bit               word_taken;

  // Wall test for one grid cell: rooms of 4x4 with hashed doors and pillars.
  function automatic bit wall_at(longint x, longint y);
    bit [31:0] room_x, room_y, h;
    int        lx, ly;
    if (x < 0) x = -x + MIRROR_OFS;
    if (y < 0) y = -y + MIRROR_OFS;
    room_x = 32'(x / 4);
    room_y = 32'(y / 4);
    lx = int'(x % 4);
    ly = int'(y % 4);
    h = (room_x * 32'd73856093) ^ (room_y * 32'd19349663);
    h = (h ^ (h >> 16)) * 32'd2654435761;
    if (lx == 0 && ly == 0) return 1'b1;
    if (lx == 0) return !(ly == 2 && h[0]);
    if (ly == 0) return !(lx == 2 && h[1]);
    return lx == 2 && ly == 2 && h[2];
  endfunction

  // Reciprocal step length along one axis, Q.24; zero means infinite.
  function automatic longint unsigned step_len(longint r);
    longint unsigned a;
    a = (r < 0) ? -r : r;
    if (a == 0) return 64'd1 << 39;
    return ((64'd1 << 30) / a) << 8;
  endfunction

  // Casts the ray of one column against the current camera.
  function automatic ray_hit_t cast_ray(logic [COL_W-1:0] col);
    ray_hit_t        r;
    byte             ramp[10];
    longint          cam, rx, ry, mx, my, stx, sty, height, mid, top, bot;
    longint unsigned dx, dy, sx, sy, perp, dist_v, shade;
    bit              side, hit;
    ramp = '{"@", "%", "#", "*", "+", "=", "-", ":", ".", " "};
    cam = (2 * longint'(col) * 16384) / COLUMNS - 16384;
    rx = dir_x + ((plane_x * cam) >>> 14);
    ry = dir_y + ((plane_y * cam) >>> 14);
    mx = cam_x >>> 8;
    my = cam_y >>> 8;
    dx = step_len(rx);
    dy = step_len(ry);
    if (rx < 0) begin
      stx = -1;
      sx = (cam_x & 255) * dx;
    end else begin
      stx = 1;
      sx = (256 - (cam_x & 255)) * dx;
    end
    if (ry < 0) begin
      sty = -1;
      sy = (cam_y & 255) * dy;
    end else begin
      sty = 1;
      sy = (256 - (cam_y & 255)) * dy;
    end
    sx = sx >> 8;
    sy = sy >> 8;
    side = 0;
    hit = 0;
    // Grid walk, one cell per step.
    for (int n = 0; n < MAX_STEPS && !hit; n++) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 0;
      end else begin
        sy += dy;
        my += sty;
        side = 1;
      end
      hit = wall_at(mx, my);
    end
    perp = side ? sy - dy : sx - dx;
    dist_v = perp >> 16;
    if (!hit || dist_v > 65535) dist_v = 65535;
    height = longint'((ROWS_N * 256) / ((dist_v != 0) ? dist_v : 1));
    mid = ROWS_N / 2 + pitch;
    top = mid - height / 2;
    bot = mid + height / 2;
    if (top < 0) top = 0;
    if (top > ROWS_N - 1) top = ROWS_N - 1;
    if (bot < 0) bot = 0;
    if (bot > ROWS_N - 1) bot = ROWS_N - 1;
    shade = (dist_v * 12) / 2560;
    if (shade > 9) shade = 9;
    if (side && shade < 9) shade++;
    r.distance = dist_v[DIST_W-1:0];
    r.side = side;
    r.first_row = top[ROW_W-1:0];
    r.last_row = bot[ROW_W-1:0];
    r.shade = ramp[shade];
    r.hit = hit;
    return r;
  endfunction

  // Writes one register and mirrors it into the predictor.
  task automatic write_reg(grc_reg_e idx, logic [POS_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CAM_POS_X:   cam_x = longint'(signed'(data));
      REG_CAM_POS_Y:   cam_y = longint'(signed'(data));
      REG_VIEW_DIR_X:  dir_x = longint'(signed'(data[DIR_W-1:0]));
      REG_VIEW_DIR_Y:  dir_y = longint'(signed'(data[DIR_W-1:0]));
      REG_CAM_PLANE_X: plane_x = longint'(signed'(data[DIR_W-1:0]));
      REG_CAM_PLANE_Y: plane_y = longint'(signed'(data[DIR_W-1:0]));
      default:         pitch = longint'(signed'(data[PITCH_W-1:0]));
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_camera(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                            logic [DIR_W-1:0] vx, logic [DIR_W-1:0] vy,
                            logic [DIR_W-1:0] qx, logic [DIR_W-1:0] qy,
                            logic [PITCH_W-1:0] p);
    write_reg(REG_CAM_POS_X, px);
    write_reg(REG_CAM_POS_Y, py);
    write_reg(REG_VIEW_DIR_X, POS_W'(vx));
    write_reg(REG_VIEW_DIR_Y, POS_W'(vy));
    write_reg(REG_CAM_PLANE_X, POS_W'(qx));
    write_reg(REG_CAM_PLANE_Y, POS_W'(qy));
    write_reg(REG_ROW_PITCH, POS_W'(p));
  endtask

  // Waits until every column has been sent and every result has come back.
  task automatic wait_drained();
    wait (column_queue.size() == 0 && ray_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random camera position: mostly near the origin, sometimes anywhere.
  function automatic logic [POS_W-1:0] rand_pos();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom);
    return POS_W'(int'($urandom_range(0, 32767)) - 16384);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stimulus and camera settings, phase by phase.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CAM_POS_X;
    cfg_data_i = '0;
    send_idle_pct = 18;
    recv_stall_pct = 57;
    mismatches = 0;
    cam_x = 640;
    cam_y = 640;
    dir_x = -16384;
    dir_y = 0;
    plane_x = 0;
    plane_y = 10813;
    pitch = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default camera: edge columns and columns beyond the screen.
    column_queue = '{0, 1, 26, 52, 53, 63};
    wait_drained();
    // Camera on a cell border facing a wall, zero plane: zero distance and
    // an infinite step length along y, with the largest pitch.
    set_camera(24'h000100, 24'h000180, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 3'd3);
    column_queue = '{0, 26, 63};
    wait_drained();
    // Extreme positions and directions, smallest pitch.
    set_camera(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 3'b100);
    column_queue = '{0, 31, 52, 63};
    wait_drained();
    set_camera(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 3'b110);
    column_queue = '{0, 21, 42, 63};
    wait_drained();
    // Negative position with the default view.
    set_camera(24'hFFFD80, 24'hFFFE40, 16'hC000, 16'h0000, 16'h0000, 16'd10813, 3'd2);
    column_queue = '{0, 13, 52};
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 18;
        recv_stall_pct = 57;
      end else if (p < 6) begin
        send_idle_pct = 57;
        recv_stall_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      set_camera(rand_pos(), rand_pos(), DIR_W'($urandom), DIR_W'($urandom),
                 DIR_W'($urandom), DIR_W'($urandom), PITCH_W'($urandom));
      for (int i = 0; i < COLUMNS_PER_PHASE; i++)
        column_queue.push_back(COL_W'($urandom_range(0, 63)));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Sender and receiver stall: a new word is offered at the falling edge once the last was taken.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      column_i <= '0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || word_taken) begin
        if (column_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          column_i <= column_queue[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      word_taken = 1'b0;
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Accepted columns are predicted; accepted results are checked in order.
  always @(posedge clk_i) begin
    ray_hit_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ray_queue.push_back(cast_ray(column_i));
      void'(column_queue.pop_front());
      word_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ray_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word at cycle %0d", cycles);
      end else begin
        want = ray_queue.pop_front();
        if (want.distance != wall_distance_o || want.side != hit_side_o ||
            want.first_row != span_start_o || want.last_row != span_end_o ||
            want.shade != wall_char_o || want.hit != hit_found_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected dist %0d side %0d rows %0d..%0d char %0d hit %0d",
                     want.distance, want.side, want.first_row, want.last_row,
                     want.shade, want.hit);
            $display("          got dist %0d side %0d rows %0d..%0d char %0d hit %0d",
                     wall_distance_o, hit_side_o, span_start_o, span_end_o,
                     wall_char_o, hit_found_o);
          end
        end
      end
    end
  end

  initial cycles = 0;
  initial word_taken = 1'b0;

endmodule

// File: grid_raycast_column.f
+incdir+sv
sv/grc_pkg.sv
sv/grc_div_cell.sv
sv/grc_div_chain.sv
sv/grid_raycast_column.sv
sv/grc_port_checker.sv
dv/testbench.sv
